// File: rtl/cflm_pkg.sv
// Shared types, constants and the CRC byte fold for the frame link monitor.
`default_nettype none

package cflm_pkg;

    // Operation codes carried by each input word.
    typedef enum logic [1:0] {
        OP_BYTE = 2'd0,
        OP_TICK = 2'd1,
        OP_SLOT = 2'd2
    } op_t;

    // Configuration register indexes.
    localparam logic [1:0] REG_RX_TIMEOUT   = 2'd0;
    localparam logic [1:0] REG_MAX_BAD      = 2'd1;
    localparam logic [1:0] REG_CONN_TIMEOUT = 2'd2;

    localparam logic [15:0] RX_TIMEOUT_RESET   = 16'd2000;
    localparam logic [2:0]  MAX_BAD_RESET      = 3'd5;
    localparam logic [15:0] CONN_TIMEOUT_RESET = 16'd500;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'h1021;

    localparam logic [15:0] PING_WRAP = 16'd65000;

    // Division by five of a 35-bit value: 2^16 = 5 * 13107 + 1, so the top part
    // folds into a 20-bit remainder sum, which a reciprocal multiply finishes.
    localparam logic [13:0] DIV5_SPLIT = 14'd13107;
    localparam logic [21:0] DIV5_RECIP = 22'd838861;

    typedef struct packed {
        logic [15:0] rx_timeout;
        logic [2:0]  max_bad;
        logic [15:0] conn_timeout;
    } cfg_t;

    typedef struct packed {
        logic        frame_done;
        logic        crc_ok;
        logic        recovery_done;
        logic        connected;
        logic [31:0] since_last_receive;
        logic [31:0] round_trip;
        logic [31:0] min_round_trip;
        logic [31:0] max_round_trip;
        logic [31:0] crc_error_count;
        logic [31:0] recovery_tally;
        logic [15:0] ping_seq_number;
    } status_t;

    // Request to the averaging stage.
    typedef struct packed {
        logic        update;
        logic        direct;
        logic [31:0] rtt;
        logic [34:0] dividend;
    } avg_req_t;

    function automatic logic [15:0] crc_fold(input logic [15:0] crc, input logic [7:0] data);
        logic [15:0] c;
        c = crc ^ {data, 8'h00};
        for (int k = 0; k < 8; k++) begin
            if (c[15])
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            else
                c = {c[14:0], 1'b0};
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// File: rtl/cflm_frame_stage.sv
// Framing, CRC check, timers, counters and round-trip statistics for one word.
`default_nettype none

module cflm_frame_stage #(
    parameter int PAYLOAD_FLOATS   = 7,
    parameter int PING_FLOAT_INDEX = 6
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               load,
    input  logic [1:0]         operation,
    input  logic [7:0]         data_byte,
    input  cflm_pkg::cfg_t     cfg,
    input  logic [31:0]        avg_cur,
    output cflm_pkg::status_t  status_next,
    output cflm_pkg::avg_req_t req_next
);
    import cflm_pkg::*;

    localparam int PAYLOAD_BYTES = 4 * PAYLOAD_FLOATS;
    localparam int POS_W         = $clog2(PAYLOAD_BYTES + 2);
    localparam int PING_BASE     = 4 * PING_FLOAT_INDEX;
    localparam bit PING_IN       = PING_FLOAT_INDEX < PAYLOAD_FLOATS;
    localparam logic [POS_W-1:0] POS_CRC_LO = POS_W'(PAYLOAD_BYTES);
    localparam logic [POS_W-1:0] POS_LAST   = POS_W'(PAYLOAD_BYTES + 1);

    logic [POS_W-1:0] pos_reg, pos_next;
    logic [15:0] crc_reg, crc_next;
    logic [31:0] ping_reg, ping_next;
    logic [7:0]  rx_lo_reg, rx_lo_next;
    logic [31:0] now_reg, now_next;
    logic [31:0] since_reg, since_next;
    logic        rx_seen_reg, rx_seen_next;
    logic [31:0] rtt_run_reg, rtt_run_next;
    logic [2:0]  bad_run_reg, bad_run_next;
    logic [31:0] rtt_latest_reg, rtt_latest_next;
    logic [31:0] rtt_min_reg, rtt_min_next;
    logic [31:0] rtt_max_reg, rtt_max_next;
    logic [31:0] fail_total_reg, fail_total_next;
    logic [31:0] rec_total_reg, rec_total_next;
    logic [15:0] ping_cnt_reg, ping_cnt_next;

    logic        frame_done;
    logic        crc_ok;
    logic        recovered;
    logic        rtt_update;
    logic [2:0]  bad_run_inc;

    always_comb
    begin
        pos_next        = pos_reg;
        crc_next        = crc_reg;
        ping_next       = ping_reg;
        rx_lo_next      = rx_lo_reg;
        now_next        = now_reg;
        since_next      = since_reg;
        rx_seen_next    = rx_seen_reg;
        rtt_run_next    = rtt_run_reg;
        bad_run_next    = bad_run_reg;
        rtt_latest_next = rtt_latest_reg;
        rtt_min_next    = rtt_min_reg;
        rtt_max_next    = rtt_max_reg;
        fail_total_next = fail_total_reg;
        rec_total_next  = rec_total_reg;
        ping_cnt_next   = ping_cnt_reg;
        frame_done      = 1'b0;
        crc_ok          = 1'b0;
        recovered       = 1'b0;
        rtt_update      = 1'b0;
        bad_run_inc     = bad_run_reg + 3'd1;

        unique case (operation)
            OP_BYTE:
            begin
                if (pos_reg == '0)
                    ping_next = '0;
                if (pos_reg < POS_CRC_LO)
                begin
                    crc_next = crc_fold(crc_reg, data_byte);
                    for (int j = 0; j < 4; j++)
                    begin
                        if (PING_IN && pos_reg == POS_W'(PING_BASE + j))
                            ping_next[8*j +: 8] = data_byte;
                    end
                    pos_next = pos_reg + POS_W'(1);
                end
                else if (pos_reg == POS_CRC_LO)
                begin
                    rx_lo_next = data_byte;
                    pos_next   = pos_reg + POS_W'(1);
                end
                else
                begin
                    frame_done = 1'b1;
                    if ({data_byte, rx_lo_reg} == crc_reg)
                    begin
                        crc_ok       = 1'b1;
                        rtt_update   = |ping_reg[30:0];
                        bad_run_next = '0;
                        since_next   = '0;
                        // A frame stamped at time zero still reads as never received.
                        rx_seen_next = |now_reg;
                    end
                    else
                    begin
                        fail_total_next = fail_total_reg + 32'd1;
                        bad_run_next    = bad_run_inc;
                        recovered       = bad_run_inc >= cfg.max_bad;
                    end
                    pos_next = '0;
                    crc_next = CRC_INIT;
                end
            end
            OP_TICK:
            begin
                now_next     = now_reg + 32'd1;
                since_next   = since_reg + 32'd1;
                rtt_run_next = rtt_run_reg + 32'd1;
            end
            OP_SLOT:
            begin
                recovered     = rx_seen_reg && (since_reg > {16'd0, cfg.rx_timeout});
                ping_cnt_next = (ping_cnt_reg >= PING_WRAP) ? 16'd1 : ping_cnt_reg + 16'd1;
                rtt_run_next  = '0;
            end
            default:
            begin
            end
        endcase

        if (recovered)
        begin
            rec_total_next = rec_total_reg + 32'd1;
            bad_run_next   = '0;
            pos_next       = '0;
            crc_next       = CRC_INIT;
        end

        if (rtt_update)
        begin
            rtt_latest_next = rtt_run_reg;
            if (rtt_min_reg == '0 || rtt_run_reg < rtt_min_reg)
                rtt_min_next = rtt_run_reg;
            if (rtt_run_reg > rtt_max_reg)
                rtt_max_next = rtt_run_reg;
        end
    end

    always_comb
    begin
        status_next.frame_done         = frame_done;
        status_next.crc_ok             = crc_ok;
        status_next.recovery_done      = recovered;
        status_next.connected          = rx_seen_next &&
                                         (since_next <= {16'd0, cfg.conn_timeout});
        status_next.since_last_receive = rx_seen_next ? since_next : '1;
        status_next.round_trip         = rtt_latest_next;
        status_next.min_round_trip     = rtt_min_next;
        status_next.max_round_trip     = rtt_max_next;
        status_next.crc_error_count    = fail_total_next;
        status_next.recovery_tally     = rec_total_next;
        status_next.ping_seq_number    = ping_cnt_next;

        req_next.update   = rtt_update;
        req_next.direct   = avg_cur == '0;
        req_next.rtt      = rtt_run_reg;
        req_next.dividend = {1'b0, avg_cur, 2'b00} + {3'b000, rtt_run_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg        <= '0;
            crc_reg        <= CRC_INIT;
            ping_reg       <= '0;
            rx_lo_reg      <= '0;
            now_reg        <= '0;
            since_reg      <= '0;
            rx_seen_reg    <= 1'b0;
            rtt_run_reg    <= '0;
            bad_run_reg    <= '0;
            rtt_latest_reg <= '0;
            rtt_min_reg    <= '0;
            rtt_max_reg    <= '0;
            fail_total_reg <= '0;
            rec_total_reg  <= '0;
            ping_cnt_reg   <= '0;
        end
        else if (load)
        begin
            pos_reg        <= pos_next;
            crc_reg        <= crc_next;
            ping_reg       <= ping_next;
            rx_lo_reg      <= rx_lo_next;
            now_reg        <= now_next;
            since_reg      <= since_next;
            rx_seen_reg    <= rx_seen_next;
            rtt_run_reg    <= rtt_run_next;
            bad_run_reg    <= bad_run_next;
            rtt_latest_reg <= rtt_latest_next;
            rtt_min_reg    <= rtt_min_next;
            rtt_max_reg    <= rtt_max_next;
            fail_total_reg <= fail_total_next;
            rec_total_reg  <= rec_total_next;
            ping_cnt_reg   <= ping_cnt_next;
        end
    end

`ifndef SYNTHESIS
    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= POS_LAST)
        else $error("byte position beyond the end of the frame");

    a_ok_needs_done: assert property (@(posedge clk) disable iff (!rst_n)
        status_next.crc_ok |-> status_next.frame_done)
        else $error("CRC match flagged without a completed frame");

    a_recovery_restarts: assert property (@(posedge clk) disable iff (!rst_n)
        (load && status_next.recovery_done) |=> (pos_reg == '0 && bad_run_reg == '0))
        else $error("recovery did not restart framing");
`endif

endmodule

`default_nettype wire

// File: rtl/cflm_avg_div.sv
// Running round-trip average: floor((4*avg + rtt) / 5) by constant division, or rtt itself while avg is zero.
`default_nettype none

module cflm_avg_div (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               load,
    input  cflm_pkg::avg_req_t req,
    output logic [31:0]        avg
);
    import cflm_pkg::*;

    logic [31:0] avg_reg, avg_next;
    logic [18:0] x_hi;
    logic [15:0] x_lo;
    logic [19:0] fold_sum;
    logic [41:0] fold_prod;
    logic [32:0] hi_part;
    logic [32:0] quotient;

    always_comb
    begin
        x_hi      = req.dividend[34:16];
        x_lo      = req.dividend[15:0];
        fold_sum  = {1'b0, x_hi} + {4'd0, x_lo};
        fold_prod = {22'd0, fold_sum} * {20'd0, DIV5_RECIP};
        hi_part   = {14'd0, x_hi} * {19'd0, DIV5_SPLIT};
        quotient  = hi_part + {13'd0, fold_prod[41:22]};
        if (req.direct)
            avg_next = req.rtt;
        else
            avg_next = quotient[31:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            avg_reg <= '0;
        else if (load && req.update)
            avg_reg <= avg_next;
    end

    assign avg = avg_reg;

endmodule

`default_nettype wire

// File: rtl/crc_frame_link_monitor.sv
// Top level of the frame link monitor: handshakes, configuration and pipeline registers.
`default_nettype none

// The monitor takes one word per clock: a received frame byte, a millisecond
// tick or a transmit slot, and returns exactly one status word for each. Each
// word passes three registers (input, status, result), in that order, before
// its status word is presented at the outputs, and a new word is accepted in
// every cycle that the result side keeps draining. The first stage
// does the framing, the byte-wide CRC-16/CCITT-FALSE fold, the timers, the
// counters and the round-trip minimum and maximum; the second stage divides the
// running average by five with a constant reciprocal and writes the average
// register. Back-to-back average updates cannot collide, as two completed
// frames are at least six bytes apart. Configuration is taken through a plain
// write port and must only be written while the block is idle. Times are kept
// as elapsed counters that ticks advance, which gives the same wrapping
// arithmetic as absolute time stamps.
module crc_frame_link_monitor #(
    parameter int PAYLOAD_FLOATS   = 7,
    parameter int PING_FLOAT_INDEX = 6
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write_en,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  operation,
    input  logic [7:0]  data_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        frame_done,
    output logic        crc_ok,
    output logic        recovery_done,
    output logic        connected,
    output logic [31:0] since_last_receive,
    output logic [31:0] round_trip,
    output logic [31:0] min_round_trip,
    output logic [31:0] max_round_trip,
    output logic [31:0] avg_round_trip,
    output logic [31:0] crc_error_count,
    output logic [31:0] recovery_tally,
    output logic [15:0] ping_seq_number
);
    import cflm_pkg::*;

    cfg_t cfg_reg;

    // Input register.
    logic        in_valid_reg;
    logic [1:0]  in_op_reg;
    logic [7:0]  in_byte_reg;

    // Status register, between the two stages.
    logic        mid_valid_reg;
    status_t     mid_status_reg;
    avg_req_t    mid_req_reg;

    // Result register.
    logic        out_valid_reg;
    status_t     out_status_reg;

    status_t     status_next;
    avg_req_t    req_next;
    logic [31:0] avg_value;

    logic        in_load;
    logic        mid_load;
    logic        out_load;

    // Each register loads when it is empty or its contents move on.
    assign out_load = mid_valid_reg && (!out_valid_reg || out_ready);
    assign mid_load = in_valid_reg && (!mid_valid_reg || out_load);
    assign in_ready = !in_valid_reg || mid_load;
    assign in_load  = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.rx_timeout   <= RX_TIMEOUT_RESET;
            cfg_reg.max_bad      <= MAX_BAD_RESET;
            cfg_reg.conn_timeout <= CONN_TIMEOUT_RESET;
        end
        else if (cfg_write_en)
        begin
            unique case (cfg_index)
                REG_RX_TIMEOUT:   cfg_reg.rx_timeout   <= cfg_data;
                REG_MAX_BAD:      cfg_reg.max_bad      <= cfg_data[2:0];
                REG_CONN_TIMEOUT: cfg_reg.conn_timeout <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            mid_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_load || (in_valid_reg && !mid_load);
            mid_valid_reg <= mid_load || (mid_valid_reg && !out_load);
            out_valid_reg <= out_load || (out_valid_reg && !out_ready);
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_load)
        begin
            in_op_reg   <= operation;
            in_byte_reg <= data_byte;
        end
        if (mid_load)
        begin
            mid_status_reg <= status_next;
            mid_req_reg    <= req_next;
        end
        if (out_load)
            out_status_reg <= mid_status_reg;
    end

    cflm_frame_stage #(
        .PAYLOAD_FLOATS   (PAYLOAD_FLOATS),
        .PING_FLOAT_INDEX (PING_FLOAT_INDEX)
    ) u_frame_stage (
        .clk         (clk),
        .rst_n       (rst_n),
        .load        (mid_load),
        .operation   (in_op_reg),
        .data_byte   (in_byte_reg),
        .cfg         (cfg_reg),
        .avg_cur     (avg_value),
        .status_next (status_next),
        .req_next    (req_next)
    );

    // The average register loads together with the result register, so it
    // always matches the word on show.
    cflm_avg_div u_avg_div (
        .clk   (clk),
        .rst_n (rst_n),
        .load  (out_load),
        .req   (mid_req_reg),
        .avg   (avg_value)
    );

    assign out_valid          = out_valid_reg;
    assign frame_done         = out_status_reg.frame_done;
    assign crc_ok             = out_status_reg.crc_ok;
    assign recovery_done      = out_status_reg.recovery_done;
    assign connected          = out_status_reg.connected;
    assign since_last_receive = out_status_reg.since_last_receive;
    assign round_trip         = out_status_reg.round_trip;
    assign min_round_trip     = out_status_reg.min_round_trip;
    assign max_round_trip     = out_status_reg.max_round_trip;
    assign avg_round_trip     = avg_value;
    assign crc_error_count    = out_status_reg.crc_error_count;
    assign recovery_tally     = out_status_reg.recovery_tally;
    assign ping_seq_number    = out_status_reg.ping_seq_number;

`ifndef SYNTHESIS
    a_no_avg_collision: assert property (@(posedge clk) disable iff (!rst_n)
        (mid_valid_reg && mid_req_reg.update && in_valid_reg) |-> !req_next.update)
        else $error("two average updates in flight at once");
`endif

endmodule

`default_nettype wire
